// ===== hw/rtl/fwve_pkg.sv =====
package fwve_pkg;

  // Ring of stored samples.
  localparam int HISTORY_DEPTH = 16;
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  // Window span register.
  localparam int              SPAN_W     = 4;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 4'd9;

  // Width used for the reference index arithmetic.
  localparam int CALC_W = PTR_W + SPAN_W + 1;

  // Field widths.
  localparam int POS_W  = 32;
  localparam int TIME_W = 32;
  localparam int VEL_W  = 32;
  localparam int USED_W = 5;
  localparam int DIFF_W = POS_W + 1;
  localparam int HIST_W = 3 * POS_W + TIME_W;

  // Scaling from microseconds to seconds.
  localparam int                 SCALE_W        = 20;
  localparam logic [SCALE_W-1:0] MICROS_PER_SEC = 20'd1000000;
  localparam int                 NUM_W          = DIFF_W + SCALE_W;

  // Divider: quotient bits produced, two per cycle.
  localparam int QUO_W     = 34;
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Saturation limits.
  localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One differencing job as handed from front to back.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic [TIME_W-1:0]        dt;
    logic [USED_W-1:0]        used;
  } job_t;

endpackage

// ===== hw/rtl/fwve_mem.sv =====
module fwve_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] store [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/fwve_front.sv =====
module fwve_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fwve_pkg::SPAN_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [fwve_pkg::POS_W-1:0] pos_x,
  input  logic signed [fwve_pkg::POS_W-1:0] pos_y,
  input  logic signed [fwve_pkg::POS_W-1:0] pos_z,
  input  logic [fwve_pkg::TIME_W-1:0]   stamp_us,
  output logic                          push,
  output fwve_pkg::job_t                job,
  input  logic                          q_full
);

  logic [fwve_pkg::SPAN_W-1:0] window_span;
  logic [fwve_pkg::PTR_W-1:0]  write_pointer;
  logic [fwve_pkg::CNT_W-1:0]  stored_count;
  logic                        pend;
  logic                        pend_result;
  logic [fwve_pkg::USED_W-1:0] pend_used;
  logic [fwve_pkg::POS_W-1:0]  new_x, new_y, new_z;
  logic [fwve_pkg::TIME_W-1:0] new_t;

  logic                         accept;
  logic [fwve_pkg::CNT_W-1:0]   count_next;
  logic [fwve_pkg::PTR_W-1:0]   pointer_next;
  logic                         has_result;
  logic [fwve_pkg::CALC_W-1:0]  span_c, limit_c, back_c, wp_c, ref_c;
  logic [fwve_pkg::PTR_W-1:0]   ref_idx;
  logic [fwve_pkg::HIST_W-1:0]  rd_data;
  logic [fwve_pkg::POS_W-1:0]   ref_x, ref_y, ref_z;
  logic [fwve_pkg::TIME_W-1:0]  ref_t;

  // An item is taken only when no lookup is pending and the queue has room.
  assign in_stall = pend || q_full;
  assign accept   = in_valid && !in_stall;

  // Fill count and ring pointer after this item.
  assign count_next = (stored_count == fwve_pkg::CNT_W'(fwve_pkg::HISTORY_DEPTH)) ?
                      stored_count : stored_count + 1'b1;
  assign pointer_next = (write_pointer == fwve_pkg::PTR_W'(fwve_pkg::HISTORY_DEPTH - 1)) ?
                        '0 : write_pointer + 1'b1;
  assign has_result = count_next >= fwve_pkg::CNT_W'(2);

  // Intervals back: a zero span counts as one, clamped to what is stored.
  always_comb begin
    span_c  = (window_span == '0) ? fwve_pkg::CALC_W'(1) : fwve_pkg::CALC_W'(window_span);
    limit_c = fwve_pkg::CALC_W'(count_next) - fwve_pkg::CALC_W'(1);
    back_c  = (span_c > limit_c) ? limit_c : span_c;
    wp_c    = fwve_pkg::CALC_W'(write_pointer);
    if (wp_c >= back_c) begin
      ref_c = wp_c - back_c;
    end else begin
      ref_c = wp_c + fwve_pkg::CALC_W'(fwve_pkg::HISTORY_DEPTH) - back_c;
    end
    ref_idx = ref_c[fwve_pkg::PTR_W-1:0];
  end

  // Sample history: newest is written while the reference is read.
  fwve_mem #(
    .WIDTH (fwve_pkg::HIST_W),
    .DEPTH (fwve_pkg::HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (write_pointer),
    .wr_data ({pos_x, pos_y, pos_z, stamp_us}),
    .rd_en   (accept),
    .rd_addr (ref_idx),
    .rd_data (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_span   <= fwve_pkg::SPAN_RESET;
      write_pointer <= '0;
      stored_count  <= '0;
      pend          <= 1'b0;
      pend_result   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_span <= cfg_data;
      end
      pend <= accept;
      if (accept) begin
        write_pointer <= pointer_next;
        stored_count  <= count_next;
        pend_result   <= has_result;
      end
    end
  end

  // Newest sample held for the difference step.
  always_ff @(posedge clk) begin
    if (accept) begin
      new_x     <= pos_x;
      new_y     <= pos_y;
      new_z     <= pos_z;
      new_t     <= stamp_us;
      pend_used <= fwve_pkg::USED_W'(back_c + fwve_pkg::CALC_W'(1));
    end
  end

  // Differences against the reference sample, pushed as one job.
  assign {ref_x, ref_y, ref_z, ref_t} = rd_data;
  assign push     = pend && pend_result;
  assign job.dx   = {new_x[fwve_pkg::POS_W-1], new_x} - {ref_x[fwve_pkg::POS_W-1], ref_x};
  assign job.dy   = {new_y[fwve_pkg::POS_W-1], new_y} - {ref_y[fwve_pkg::POS_W-1], ref_y};
  assign job.dz   = {new_z[fwve_pkg::POS_W-1], new_z} - {ref_z[fwve_pkg::POS_W-1], ref_z};
  assign job.dt   = new_t - ref_t;
  assign job.used = pend_used;

`ifndef ASSERT_OFF
  // A sample that gives a result never reads the slot it is writing.
  a_ref_differs: assert property (@(posedge clk) disable iff (rst)
    accept && has_result |-> ref_idx != write_pointer)
    else $error("reference slot equals write slot");

  // The queue always has room for the job of an accepted item.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into a full queue");

  // The fill count never goes past the ring depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stored_count <= fwve_pkg::CNT_W'(fwve_pkg::HISTORY_DEPTH))
    else $error("fill count beyond ring depth");
`endif

endmodule

// ===== hw/rtl/fwve_queue.sv =====
module fwve_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fwve_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output fwve_pkg::job_t head
);

  fwve_pkg::job_t               entries [fwve_pkg::QUEUE_DEPTH];
  logic [fwve_pkg::QPTR_W-1:0]  wr_ptr;
  logic [fwve_pkg::QPTR_W-1:0]  rd_ptr;
  logic [fwve_pkg::QCNT_W-1:0]  count;

  assign full  = count == fwve_pkg::QCNT_W'(fwve_pkg::QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == fwve_pkg::QPTR_W'(fwve_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == fwve_pkg::QPTR_W'(fwve_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/fwve_back.sv =====
module fwve_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  fwve_pkg::job_t                    q_job,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fwve_pkg::VEL_W-1:0] vel_x,
  output logic signed [fwve_pkg::VEL_W-1:0] vel_y,
  output logic signed [fwve_pkg::VEL_W-1:0] vel_z,
  output logic [fwve_pkg::USED_W-1:0]       samples_used,
  output logic                              time_error
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  state_t                        state;
  logic [1:0]                    axis;
  logic [fwve_pkg::STEP_W-1:0]   step;
  fwve_pkg::job_t                job;
  logic [fwve_pkg::NUM_W-1:0]    num;
  logic                          neg;
  logic [fwve_pkg::TIME_W-1:0]   rem;
  logic [fwve_pkg::QUO_W-1:0]    quo;
  logic [fwve_pkg::QUO_W-1:0]    dvd;

  logic signed [fwve_pkg::DIFF_W-1:0] cur_diff;
  logic [fwve_pkg::DIFF_W-1:0]        mag;
  logic [fwve_pkg::NUM_W-1:0]         prod;
  logic [fwve_pkg::TIME_W:0]          st1, st2;
  logic                               overflow;
  logic [fwve_pkg::VEL_W-1:0]         sat_res, fin_res;

  // One restoring step: returns the quotient bit over the new remainder.
  function automatic logic [fwve_pkg::TIME_W:0] div_step(
    logic [fwve_pkg::TIME_W-1:0] r,
    logic                        b,
    logic [fwve_pkg::TIME_W-1:0] d
  );
    logic [fwve_pkg::TIME_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, fwve_pkg::TIME_W'(t - {1'b0, d})};
    end
    return {1'b0, t[fwve_pkg::TIME_W-1:0]};
  endfunction

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_valid = state == S_OUT;

  // Difference of the axis in work and its magnitude scaled to seconds.
  always_comb begin
    unique case (axis)
      AX_X:    cur_diff = job.dx;
      AX_Y:    cur_diff = job.dy;
      default: cur_diff = job.dz;
    endcase
    mag  = cur_diff[fwve_pkg::DIFF_W-1] ? -cur_diff : cur_diff;
    prod = mag * fwve_pkg::MICROS_PER_SEC;
  end

  // Two quotient bits a cycle, and the saturated results.
  always_comb begin
    st1      = div_step(rem, dvd[fwve_pkg::QUO_W-1], job.dt);
    st2      = div_step(st1[fwve_pkg::TIME_W-1:0], dvd[fwve_pkg::QUO_W-2], job.dt);
    overflow = fwve_pkg::TIME_W'(num[fwve_pkg::NUM_W-1:fwve_pkg::QUO_W]) >= job.dt;
    sat_res  = neg ? fwve_pkg::VEL_MIN : fwve_pkg::VEL_MAX;
    if (neg) begin
      fin_res = (quo > fwve_pkg::QUO_W'(fwve_pkg::VEL_MIN)) ?
                fwve_pkg::VEL_MIN : -quo[fwve_pkg::VEL_W-1:0];
    end else begin
      fin_res = (quo > fwve_pkg::QUO_W'(fwve_pkg::VEL_MAX)) ?
                fwve_pkg::VEL_MAX : quo[fwve_pkg::VEL_W-1:0];
    end
  end

  // Sequencer: three axes in turn through the one divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= AX_X;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            axis  <= AX_X;
            state <= (q_job.dt == '0) ? S_OUT : S_MUL;
          end
        end
        S_MUL: begin
          state <= S_CHK;
        end
        S_CHK: begin
          step <= '0;
          if (!overflow) begin
            state <= S_DIV;
          end else if (axis == AX_Z) begin
            state <= S_OUT;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_MUL;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == fwve_pkg::STEP_W'(fwve_pkg::DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (axis == AX_Z) begin
            state <= S_OUT;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job          <= q_job;
      samples_used <= q_job.used;
      time_error   <= q_job.dt == '0;
      if (q_job.dt == '0) begin
        vel_x <= '0;
        vel_y <= '0;
        vel_z <= '0;
      end
    end
    if (state == S_MUL) begin
      num <= prod;
      neg <= cur_diff[fwve_pkg::DIFF_W-1];
    end
    if (state == S_CHK) begin
      rem <= fwve_pkg::TIME_W'(num[fwve_pkg::NUM_W-1:fwve_pkg::QUO_W]);
      dvd <= num[fwve_pkg::QUO_W-1:0];
      quo <= '0;
    end
    if (state == S_DIV) begin
      rem <= st2[fwve_pkg::TIME_W-1:0];
      dvd <= {dvd[fwve_pkg::QUO_W-3:0], 2'b00};
      quo <= {quo[fwve_pkg::QUO_W-3:0], st1[fwve_pkg::TIME_W], st2[fwve_pkg::TIME_W]};
    end
    // Result of the axis in work, saturated early or after the divide.
    if ((state == S_CHK && overflow) || state == S_FIN) begin
      unique case (axis)
        AX_X:    vel_x <= (state == S_FIN) ? fin_res : sat_res;
        AX_Y:    vel_y <= (state == S_FIN) ? fin_res : sat_res;
        default: vel_z <= (state == S_FIN) ? fin_res : sat_res;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A zero time difference always reports zero velocities.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && time_error |-> vel_x == '0 && vel_y == '0 && vel_z == '0)
    else $error("time error with non-zero velocity");

  // The partial remainder stays below the divisor throughout the divide.
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < job.dt)
    else $error("divider remainder out of range");

  // A window always spans at least two samples.
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> samples_used >= fwve_pkg::USED_W'(2))
    else $error("window spans fewer than two samples");
`endif

endmodule

// ===== hw/rtl/fixed_window_velocity_estimator.sv =====
// Velocity from timestamped 3-axis positions by a fixed-window finite difference.
// Each sample is stored in a 16-entry ring; from the second sample on, one result
// gives per axis (newest - reference) * 1e6 / (stamp difference), truncated toward
// zero and saturated to 32 bits, with the reference window_span samples back (a zero
// span counts as one) or the oldest stored sample while the ring is still filling.
// A zero stamp difference gives zero velocities with time_error set. The front end
// registers each sample and its reference read, then pushes the differences to the
// back end through a two-entry queue. The back end runs the three axes in turn
// through one shared restoring divider that makes two quotient bits a cycle, and
// that divider sets the sustained rate. window_span (reset 9) is written through
// cfg_we and cfg_data; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module fixed_window_velocity_estimator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fwve_pkg::SPAN_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fwve_pkg::POS_W-1:0] pos_x,
  input  logic signed [fwve_pkg::POS_W-1:0] pos_y,
  input  logic signed [fwve_pkg::POS_W-1:0] pos_z,
  input  logic [fwve_pkg::TIME_W-1:0]       stamp_us,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fwve_pkg::VEL_W-1:0] vel_x,
  output logic signed [fwve_pkg::VEL_W-1:0] vel_y,
  output logic signed [fwve_pkg::VEL_W-1:0] vel_z,
  output logic [fwve_pkg::USED_W-1:0]       samples_used,
  output logic                              time_error
);

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  fwve_pkg::job_t push_job;
  fwve_pkg::job_t head_job;

  // Sample intake, history ring and differencing.
  fwve_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .stamp_us (stamp_us),
    .push     (push),
    .job      (push_job),
    .q_full   (q_full)
  );

  // Job queue between the two halves.
  fwve_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_job)
  );

  // Scaling, division and saturation.
  fwve_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .vel_z        (vel_z),
    .samples_used (samples_used),
    .time_error   (time_error)
  );

endmodule

// ===== tb/velocity_checker.sv =====
`timescale 1ns / 100ps

module velocity_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fwve_pkg::SPAN_W-1:0]       cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [fwve_pkg::POS_W-1:0] pos_x,
  input  logic signed [fwve_pkg::POS_W-1:0] pos_y,
  input  logic signed [fwve_pkg::POS_W-1:0] pos_z,
  input  logic [fwve_pkg::TIME_W-1:0]       stamp_us,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [fwve_pkg::VEL_W-1:0] vel_x,
  input  logic signed [fwve_pkg::VEL_W-1:0] vel_y,
  input  logic signed [fwve_pkg::VEL_W-1:0] vel_z,
  input  logic [fwve_pkg::USED_W-1:0]       samples_used,
  input  logic                              time_error,
  output int                                fail_count,
  output int                                pending,
  output int                                checked,
  output int                                zero_dt_seen
);

  localparam int     RING         = fwve_pkg::HISTORY_DEPTH;
  localparam longint USEC_PER_SEC = 1000000;
  localparam longint RATE_MAX     = 64'sd2147483647;
  localparam longint RATE_MIN     = -64'sd2147483648;

  // One expected velocity result.
  typedef struct packed {
    logic [fwve_pkg::VEL_W-1:0]  vx;
    logic [fwve_pkg::VEL_W-1:0]  vy;
    logic [fwve_pkg::VEL_W-1:0]  vz;
    logic [fwve_pkg::USED_W-1:0] used;
    logic                        terr;
  } velocity_t;

  velocity_t expected_velocities[$];

  // Own copy of the sample ring and the window span.
  logic [fwve_pkg::POS_W-1:0]  ring_x[RING];
  logic [fwve_pkg::POS_W-1:0]  ring_y[RING];
  logic [fwve_pkg::POS_W-1:0]  ring_z[RING];
  logic [fwve_pkg::TIME_W-1:0] ring_t[RING];
  int unsigned                 next_slot;
  int unsigned                 filled;
  logic [fwve_pkg::SPAN_W-1:0] span;

  // Scaled difference of one axis, truncated toward zero and saturated.
  function automatic logic [31:0] axis_rate(input logic [31:0] now_pos,
                                            input logic [31:0] base_pos,
                                            input logic [31:0] dt);
    longint delta;
    longint rate;
    delta = longint'($signed(now_pos)) - longint'($signed(base_pos));
    rate  = (delta * USEC_PER_SEC) / longint'({32'd0, dt});
    if (rate > RATE_MAX) rate = RATE_MAX;
    else if (rate < RATE_MIN) rate = RATE_MIN;
    return rate[31:0];
  endfunction

  // Stores an accepted sample and queues the velocity it gives, if any.
  task automatic difference_sample(input logic [31:0] px, input logic [31:0] py,
                                   input logic [31:0] pz, input logic [31:0] ts);
    int unsigned newest;
    int unsigned back;
    int unsigned base_slot;
    logic [31:0] dt;
    velocity_t   v;
    newest         = next_slot;
    ring_x[newest] = px;
    ring_y[newest] = py;
    ring_z[newest] = pz;
    ring_t[newest] = ts;
    next_slot      = (next_slot + 1) % RING;
    if (filled < RING) filled++;
    // The very first sample only fills the ring.
    if (filled < 2) return;
    // A span of zero acts as one; a short ring falls back to its oldest sample.
    back = (span == 0) ? 1 : span;
    if (back > filled - 1) back = filled - 1;
    base_slot = (newest + RING - back) % RING;
    dt        = ring_t[newest] - ring_t[base_slot];
    v.used    = 5'(back + 1);
    if (dt == 0) begin
      v.vx   = '0;
      v.vy   = '0;
      v.vz   = '0;
      v.terr = 1'b1;
    end else begin
      v.vx   = axis_rate(ring_x[newest], ring_x[base_slot], dt);
      v.vy   = axis_rate(ring_y[newest], ring_y[base_slot], dt);
      v.vz   = axis_rate(ring_z[newest], ring_z[base_slot], dt);
      v.terr = 1'b0;
    end
    expected_velocities = {expected_velocities, v};
  endtask

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Watch both channels at the rising edge.
  always @(posedge clk) begin : watch
    velocity_t want;
    if (rst) begin
      next_slot = 0;
      filled    = 0;
      span      = fwve_pkg::SPAN_RESET;
      expected_velocities.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_velocities.size() == 0) begin
          report_mismatch($sformatf("result with none expected: vel %0d %0d %0d used %0d err %0b",
                                    vel_x, vel_y, vel_z, samples_used, time_error));
        end else begin
          want = expected_velocities.pop_front();
          checked++;
          if (want.terr) zero_dt_seen++;
          if (vel_x !== want.vx)
            report_mismatch($sformatf("vel_x %0d, expected %0d", vel_x, $signed(want.vx)));
          if (vel_y !== want.vy)
            report_mismatch($sformatf("vel_y %0d, expected %0d", vel_y, $signed(want.vy)));
          if (vel_z !== want.vz)
            report_mismatch($sformatf("vel_z %0d, expected %0d", vel_z, $signed(want.vz)));
          if (samples_used !== want.used)
            report_mismatch($sformatf("samples_used %0d, expected %0d", samples_used,
                                      want.used));
          if (time_error !== want.terr)
            report_mismatch($sformatf("time_error %0b, expected %0b", time_error, want.terr));
        end
      end
      if (in_valid && !in_stall) difference_sample(pos_x, pos_y, pos_z, stamp_us);
      if (cfg_we) span = cfg_data;
    end
    pending = expected_velocities.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SEGMENTS      = 6;
  localparam int SEG_ITEMS     = 275;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [fwve_pkg::SPAN_W-1:0]       cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [fwve_pkg::POS_W-1:0] pos_x = '0;
  logic signed [fwve_pkg::POS_W-1:0] pos_y = '0;
  logic signed [fwve_pkg::POS_W-1:0] pos_z = '0;
  logic [fwve_pkg::TIME_W-1:0]       stamp_us = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [fwve_pkg::VEL_W-1:0] vel_x;
  logic signed [fwve_pkg::VEL_W-1:0] vel_y;
  logic signed [fwve_pkg::VEL_W-1:0] vel_z;
  logic [fwve_pkg::USED_W-1:0]       samples_used;
  logic                              time_error;

  int fail_count;
  int pending;
  int checked;
  int zero_dt_seen;
  int samples_sent = 0;
  int cycle_count  = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;

  // Motion state for the random part.
  logic [31:0] cur_x;
  logic [31:0] cur_y;
  logic [31:0] cur_z;
  logic [31:0] cur_stamp;
  int          freeze_left = 0;

  fixed_window_velocity_estimator DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .stamp_us     (stamp_us),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .vel_z        (vel_z),
    .samples_used (samples_used),
    .time_error   (time_error)
  );

  velocity_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .stamp_us     (stamp_us),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .vel_z        (vel_z),
    .samples_used (samples_used),
    .time_error   (time_error),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .zero_dt_seen (zero_dt_seen)
  );

  // Clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random, one decision per cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offers one item after a random gap and returns at the falling edge after acceptance.
  task automatic send_sample(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [31:0] ts);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= px;
    pos_y    <= py;
    pos_z    <= pz;
    stamp_us <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  // Waits until every expected velocity has arrived and the block has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_span(input logic [fwve_pkg::SPAN_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly steady motion with a ticking clock; sometimes a frozen clock, a jump,
  // a wrap, noise on the positions or positions at full scale.
  task automatic random_sample();
    int unsigned kind;
    logic [31:0] r;
    kind = $urandom_range(99);
    if (freeze_left > 0) begin
      freeze_left--;
    end else if (kind < 8) begin
      freeze_left = $urandom_range(17, 1);
    end else if (kind < 13) begin
      cur_stamp = $urandom();
    end else if (kind < 19) begin
      cur_stamp = 32'hFFFF_FFFF - $urandom_range(60000);
    end else begin
      cur_stamp = cur_stamp + $urandom_range(20000, 1);
    end
    kind = $urandom_range(99);
    if (kind < 10) begin
      cur_x = $urandom();
      cur_y = $urandom();
      cur_z = $urandom();
    end else if (kind < 15) begin
      cur_x = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      cur_y = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      cur_z = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else begin
      r = $urandom();
      cur_x = cur_x + {{11{r[20]}}, r[20:0]};
      r = $urandom();
      cur_y = cur_y + {{11{r[20]}}, r[20:0]};
      r = $urandom();
      cur_z = cur_z + {{11{r[20]}}, r[20:0]};
    end
    send_sample(cur_x, cur_y, cur_z, cur_stamp);
  endtask

  // Cycle counter that ends a run that has stopped making progress.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit with %0d velocities still expected.", pending);
    $display("[fixed_window_velocity_estimator] ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int i;
    int seg;
    logic [fwve_pkg::SPAN_W-1:0] seg_span[SEGMENTS];
    repeat (12) @(negedge clk);
    rst       <= 1'b0;
    gap_pct   = 23;
    stall_pct = 69;

    // Widest window: first sample, saturation both ways, a filling ring, then a full one.
    write_span(4'd15);
    send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd100);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'd101);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd103);
    send_sample(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0010_0000);
    for (i = 1; i <= 13; i++)
      send_sample(i * 32'h8000, -(i * 32'h3000), i * 7, 32'h0010_0000 + i * 5000);

    // Span of one: zero time step, a huge forward step, then a step across the wrap.
    wait_idle();
    write_span(4'd1);
    send_sample(13 * 32'h8000, -(13 * 32'h3000), 13 * 7, 32'h0010_0000 + 13 * 5000);
    send_sample(32'h7FFF_0000, 32'h8001_0000, 32'h0000_0000, 32'hFFFF_FFF0);
    send_sample(32'h7FFE_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0010);

    // Span of zero behaves as one.
    wait_idle();
    write_span(4'd0);
    send_sample(32'h7FFE_0100, 32'h8000_0100, 32'h0000_0101, 32'd1016);
    send_sample(32'h7FFE_0100, 32'h8000_0100, 32'h0000_0101, 32'd1016);
    send_sample(32'h7FFE_0200, 32'h8000_0000, 32'h0000_0001, 32'd1017);
    cur_x     = 32'h7FFE_0200;
    cur_y     = 32'h8000_0000;
    cur_z     = 32'h0000_0001;
    cur_stamp = 32'd1017;

    // Random part: two spans under each idling pattern.
    seg_span[0] = 4'd15;
    seg_span[1] = 4'd9;
    seg_span[2] = 4'($urandom_range(15));
    seg_span[3] = 4'd0;
    seg_span[4] = 4'd1;
    seg_span[5] = 4'($urandom_range(15));
    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      write_span(seg_span[seg]);
      case (seg / 2)
        0: begin
          gap_pct   = 23;
          stall_pct = 69;
        end
        1: begin
          gap_pct   = 69;
          stall_pct = 23;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      repeat (SEG_ITEMS) random_sample();
    end
    wait_idle();

    $display("Sent %0d position samples under window spans 0, 1, 9, 15 and random ones,",
             samples_sent);
    $display("with three idling patterns; %0d velocities checked, %0d with a zero time step.",
             checked, zero_dt_seen);
    if (fail_count == 0) begin
      $display("[fixed_window_velocity_estimator] OK");
    end else begin
      $display("[fixed_window_velocity_estimator] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fwve_pkg.sv
hw/rtl/fwve_mem.sv
hw/rtl/fwve_front.sv
hw/rtl/fwve_queue.sv
hw/rtl/fwve_back.sv
hw/rtl/fixed_window_velocity_estimator.sv
tb/velocity_checker.sv
tb/testbench.sv
